>>> design/hse_pkg.sv
// Shared types and constants for the Hermite spline evaluator.
// No dependencies; used by hermite_spline_evaluator_unit.
package hse_pkg;

  localparam int MAX_KNOTS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam int U_BITS        = 30;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_LOW     = 2'd1;
  localparam logic [1:0] ST_HIGH    = 2'd2;
  localparam logic [1:0] ST_NO_KNOT = 2'd3;

  typedef struct packed {
    logic               req_type;
    logic               spline_sel;
    logic        [5:0]  knot_index;
    logic        [31:0] knot_time;
    logic signed [31:0] knot_value;
    logic signed [31:0] knot_slope;
    logic               knot_empty;
    logic        [31:0] query_time;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] spline_value;
    logic        [1:0]  status;
  } out_res_t;

endpackage

>>> design/hermite_spline_evaluator_unit.sv
// An interpolating query runs two serial knot scans, a 31-step restoring divider and seven
// multiplies on one shared 36x18 multiplier; a write request is taken without leaving the
// idle state.
// One request in flight at a time; in_stall is high until the query result is registered.
// Synchronous active-low reset clears control and sets knot_count to 1; knot memories
// are not cleared. Depends on hse_pkg.
module hermite_spline_evaluator_unit #(
  parameter int MAX_KNOTS = hse_pkg::MAX_KNOTS_DEF,
  parameter int FRAC_BITS = hse_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  hse_pkg::in_req_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output hse_pkg::out_res_t out_data,
  input  logic             cfg_we,
  input  logic [6:0]       cfg_wdata
);

  localparam int IW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
  localparam int NW = (IW + 1 > 7) ? IW + 1 : 7;
  localparam int SW = 37;  // signed operand width
  localparam int MW = 36;  // magnitude width
  localparam int HW = 18;  // multiplier chunk
  localparam int PW = 2 * MW;
  localparam int AW = PW + 1 - 8 + 3;

  typedef enum logic [4:0] {
    S_IDLE, S_R0, S_R1, S_CHKN, S_LO_RD, S_LO_CK, S_HI_RD, S_HI_CK,
    S_LD_LO, S_LD_HI, S_PREP, S_DIV, S_MUL, S_MULW, S_HPOLY, S_SAT, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_U2, OP_U3, OP_W10, OP_W11, OP_X, OP_M0, OP_M1
  } op_t;

  // knot storage
  logic        [31:0] times_mem  [MAX_KNOTS];
  logic        [31:0] values_mem [2*MAX_KNOTS];
  logic        [31:0] slopes_mem [2*MAX_KNOTS];
  logic               empty_mem  [2*MAX_KNOTS];
  logic        [31:0] time_q, val_q, slope_q;
  logic               empty_q;

  state_t             state_r;
  op_t                op_r;
  logic [6:0]         knot_count_r;
  logic               sel_r;
  logic [31:0]        t_r, tlast_r, tlo_r, dt_r;
  logic [IW-1:0]      nlast_r, idx_r, lo_r, hi_r;
  logic signed [31:0] x0_r, x1_r, m0_r, m1_r;
  logic [31:0]        rem_r;
  logic [30:0]        q_r, u_r;
  logic [4:0]         div_cnt_r;
  logic               mul_hi_r;
  logic [PW-1:0]      pacc_r;
  logic signed [SW-1:0] u2_r, u3_r, h01_r, h10_r, h11_r, w10_r, w11_r;
  logic signed [AW-1:0] acc_r;
  logic               out_valid_r;
  hse_pkg::out_res_t  res_r, out_r;

  logic [IW-1:0]      taddr;
  logic [IW:0]        vaddr, waddr;
  logic [IW-1:0]      vidx;
  logic [NW-1:0]      cnt_ext, n_clamp, n_m1;
  logic               in_acc, wr_ok;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cnt_ext = NW'(knot_count_r);
  always_comb begin
    if (cnt_ext == '0) n_clamp = NW'(1);
    else if (cnt_ext > NW'(MAX_KNOTS)) n_clamp = NW'(MAX_KNOTS);
    else n_clamp = cnt_ext;
  end
  assign n_m1  = n_clamp - NW'(1);
  assign wr_ok = NW'(in_data.knot_index) < NW'(MAX_KNOTS);
  assign waddr = in_data.spline_sel ?
                 (IW+1)'(MAX_KNOTS) + {1'b0, IW'(NW'(in_data.knot_index))} :
                 {1'b0, IW'(NW'(in_data.knot_index))};

  always_comb begin
    case (state_r)
      S_R1:    taddr = nlast_r;
      S_LO_RD,
      S_HI_RD: taddr = idx_r;
      S_LD_LO: taddr = lo_r;
      S_LD_HI: taddr = hi_r;
      default: taddr = '0;
    endcase
  end
  assign vidx  = taddr;
  assign vaddr = sel_r ? (IW+1)'(MAX_KNOTS) + {1'b0, vidx} : {1'b0, vidx};

  always_ff @(posedge clk) begin
    if (in_acc && in_data.req_type == hse_pkg::REQ_WRITE && wr_ok) begin
      times_mem[IW'(NW'(in_data.knot_index))] <= in_data.knot_time;
    end
    time_q <= times_mem[taddr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.req_type == hse_pkg::REQ_WRITE && wr_ok) begin
      values_mem[waddr] <= in_data.knot_value;
      slopes_mem[waddr] <= in_data.knot_slope;
      empty_mem[waddr]  <= in_data.knot_empty;
    end
    val_q   <= values_mem[vaddr];
    slope_q <= slopes_mem[vaddr];
    empty_q <= empty_mem[vaddr];
  end

  // shared multiplier: magnitude product in two 18-bit chunks of b
  logic signed [SW-1:0] mul_a, mul_b;
  logic [SW-1:0]        a_neg_v, b_neg_v;
  logic [MW-1:0]        amag, bmag;
  logic [HW-1:0]        bchunk;
  logic [MW+HW-1:0]     partial;
  logic                 pneg;
  logic signed [PW:0]   psigned, psh;
  logic signed [AW-1:0] pterm;

  always_comb begin
    case (op_r)
      OP_U2: begin
        mul_a = SW'({6'b0, u_r});
        mul_b = SW'({6'b0, u_r});
      end
      OP_U3: begin
        mul_a = u2_r;
        mul_b = SW'({6'b0, u_r});
      end
      OP_W10: begin
        mul_a = SW'({5'b0, dt_r});
        mul_b = h10_r;
      end
      OP_W11: begin
        mul_a = SW'({5'b0, dt_r});
        mul_b = h11_r;
      end
      OP_X: begin
        mul_a = SW'({{5{x1_r[31]}}, x1_r}) - SW'({{5{x0_r[31]}}, x0_r});
        mul_b = h01_r;
      end
      OP_M0: begin
        mul_a = w10_r;
        mul_b = SW'({{5{m0_r[31]}}, m0_r});
      end
      default: begin
        mul_a = w11_r;
        mul_b = SW'({{5{m1_r[31]}}, m1_r});
      end
    endcase
  end

  assign a_neg_v = -mul_a;
  assign b_neg_v = -mul_b;
  assign amag    = mul_a[SW-1] ? a_neg_v[MW-1:0] : mul_a[MW-1:0];
  assign bmag    = mul_b[SW-1] ? b_neg_v[MW-1:0] : mul_b[MW-1:0];
  assign bchunk  = mul_hi_r ? bmag[MW-1:HW] : bmag[HW-1:0];
  assign partial = amag * bchunk;
  assign pneg    = mul_a[SW-1] ^ mul_b[SW-1];
  assign psigned = pneg ? -$signed({1'b0, pacc_r}) : $signed({1'b0, pacc_r});
  assign psh     = (op_r == OP_M0 || op_r == OP_M1) ? (psigned >>> FRAC_BITS)
                                                    : (psigned >>> hse_pkg::U_BITS);
  assign pterm   = psh[AW-1:0];

  // divider step
  logic [32:0] trial;
  assign trial = (div_cnt_r == 5'd30) ? {1'b0, rem_r} : {rem_r, 1'b0};

  logic signed [SW-1:0] uext;
  assign uext = SW'({6'b0, u_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      knot_count_r <= 7'd1;
      out_valid_r  <= 1'b0;
      mul_hi_r     <= 1'b0;
      op_r         <= OP_U2;
    end else begin
      if (cfg_we) knot_count_r <= cfg_wdata;
      if (out_valid_r && !out_stall && state_r != S_OUT) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_data.req_type == hse_pkg::REQ_QUERY) begin
            sel_r   <= in_data.spline_sel;
            t_r     <= in_data.query_time;
            nlast_r <= n_m1[IW-1:0];
            state_r <= S_R0;
          end
        end
        S_R0: state_r <= S_R1;
        S_R1: begin
          if (t_r < time_q) begin
            res_r   <= '{spline_value: '0, status: hse_pkg::ST_LOW};
            state_r <= S_OUT;
          end else begin
            state_r <= S_CHKN;
          end
        end
        S_CHKN: begin
          tlast_r <= time_q;
          if (t_r > time_q) begin
            res_r   <= '{spline_value: '0, status: hse_pkg::ST_HIGH};
            state_r <= S_OUT;
          end else begin
            idx_r   <= nlast_r;
            state_r <= S_LO_RD;
          end
        end
        S_LO_RD: state_r <= S_LO_CK;
        S_LO_CK: begin
          if (t_r >= time_q && !empty_q) begin
            lo_r    <= idx_r;
            idx_r   <= '0;
            state_r <= S_HI_RD;
          end else if (idx_r == '0) begin
            res_r   <= '{spline_value: '0, status: hse_pkg::ST_NO_KNOT};
            state_r <= S_OUT;
          end else begin
            idx_r   <= idx_r - IW'(1);
            state_r <= S_LO_RD;
          end
        end
        S_HI_RD: state_r <= S_HI_CK;
        S_HI_CK: begin
          if (t_r < time_q && !empty_q) begin
            hi_r    <= idx_r;
            state_r <= S_LD_LO;
          end else if (idx_r == nlast_r) begin
            if (t_r == tlast_r) begin
              hi_r    <= nlast_r;
              state_r <= S_LD_LO;
            end else begin
              res_r   <= '{spline_value: '0, status: hse_pkg::ST_NO_KNOT};
              state_r <= S_OUT;
            end
          end else begin
            idx_r   <= idx_r + IW'(1);
            state_r <= S_HI_RD;
          end
        end
        S_LD_LO: state_r <= S_LD_HI;
        S_LD_HI: begin
          tlo_r   <= time_q;
          x0_r    <= val_q;
          m0_r    <= slope_q;
          state_r <= S_PREP;
        end
        S_PREP: begin
          x1_r      <= val_q;
          m1_r      <= slope_q;
          dt_r      <= time_q - tlo_r;
          rem_r     <= t_r - tlo_r;
          q_r       <= '0;
          div_cnt_r <= 5'd30;
          if (lo_r == hi_r) begin
            res_r   <= '{spline_value: x0_r, status: hse_pkg::ST_OK};
            state_r <= S_OUT;
          end else if (time_q == tlo_r) begin
            u_r      <= '0;
            op_r     <= OP_U2;
            mul_hi_r <= 1'b0;
            state_r  <= S_MUL;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (trial >= {1'b0, dt_r}) begin
            rem_r <= 32'(trial - {1'b0, dt_r});
            q_r   <= {q_r[29:0], 1'b1};
          end else begin
            rem_r <= trial[31:0];
            q_r   <= {q_r[29:0], 1'b0};
          end
          div_cnt_r <= div_cnt_r - 5'd1;
          if (div_cnt_r == 5'd0) begin
            u_r      <= (trial >= {1'b0, dt_r}) ? {q_r[29:0], 1'b1} : {q_r[29:0], 1'b0};
            op_r     <= OP_U2;
            mul_hi_r <= 1'b0;
            state_r  <= S_MUL;
          end
        end
        S_MUL: begin
          if (!mul_hi_r) begin
            pacc_r   <= PW'(partial);
            mul_hi_r <= 1'b1;
          end else begin
            pacc_r   <= pacc_r + (PW'(partial) << HW);
            mul_hi_r <= 1'b0;
            state_r  <= S_MULW;
          end
        end
        S_MULW: begin
          state_r <= S_MUL;
          unique case (op_r)
            OP_U2: begin
              u2_r <= pterm[SW-1:0];
              op_r <= OP_U3;
            end
            OP_U3: begin
              u3_r    <= pterm[SW-1:0];
              state_r <= S_HPOLY;
            end
            OP_W10: begin
              w10_r <= pterm[SW-1:0];
              op_r  <= OP_W11;
            end
            OP_W11: begin
              w11_r <= pterm[SW-1:0];
              op_r  <= OP_X;
            end
            OP_X: begin
              acc_r <= AW'(x0_r) + pterm;
              op_r  <= OP_M0;
            end
            OP_M0: begin
              acc_r <= acc_r + pterm;
              op_r  <= OP_M1;
            end
            OP_M1: begin
              acc_r   <= acc_r + pterm;
              state_r <= S_SAT;
            end
            default: state_r <= S_SAT;
          endcase
        end
        S_HPOLY: begin
          h01_r   <= (u2_r <<< 1) + u2_r - (u3_r <<< 1);
          h10_r   <= uext - (u2_r <<< 1) + u3_r;
          h11_r   <= u3_r - u2_r;
          op_r    <= OP_W10;
          state_r <= S_MUL;
        end
        S_SAT: begin
          res_r.status <= hse_pkg::ST_OK;
          if (acc_r > AW'(64'sd2147483647))
            res_r.spline_value <= 32'sh7fffffff;
          else if (acc_r < -AW'(64'sd2147483648))
            res_r.spline_value <= 32'sh80000000;
          else
            res_r.spline_value <= acc_r[31:0];
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result appeared outside output state");
  a_u_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL && op_r == OP_U2) |-> (u_r <= 31'h40000000))
    else $error("normalized position above one");
  a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |=> (state_r == S_DIV || state_r == S_MUL))
    else $error("divider left to wrong state");
`endif

endmodule

>>> test/hermite_spline_evaluator_unit_tb.sv
// Self-checking testbench for hermite_spline_evaluator_unit: knot loads update an internal
// fixed-point Hermite model that predicts each spline query result, compared on the result port.
// Depends on hse_pkg and hermite_spline_evaluator_unit.
module hermite_spline_evaluator_unit_tb;

  localparam int NK         = hse_pkg::MAX_KNOTS_DEF;
  localparam int CYCLE_MAX  = 3000000;
  localparam int ITEM_GOAL  = 650;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  hse_pkg::in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  hse_pkg::out_res_t out_data;
  logic     cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;

  hermite_spline_evaluator_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // shadow spline state
  logic [31:0]        knot_tm [NK];
  logic signed [31:0] knot_val[2][NK];
  logic signed [31:0] knot_slp[2][NK];
  logic               knot_emp[2][NK];
  logic [6:0]         knot_cnt = 7'd1;

  hse_pkg::in_req_t  req_q[$];
  hse_pkg::out_res_t value_q[$];
  logic [31:0] plan_tm[NK];   // knot times as scheduled, ahead of acceptance
  bit  quiet = 0;
  int  errors = 0;
  int  items_sent = 0;
  int  queries_done = 0;
  int  writes_done = 0;
  int  phases = 0;
  int  cycles = 0;
  int  send_gap = 0;
  int  recv_gap = 0;

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic hse_pkg::out_res_t eval_spline(logic sel, logic [31:0] t);
    hse_pkg::out_res_t r;
    int n, lo, hi;
    bit have_lo, have_hi;
    longint unsigned s, dt;
    longint x0, x1, m0, m1, u, u2, u3, h01, h10, h11, w10, w11, acc;
    r = '0;
    n = (knot_cnt == 0) ? 1 : ((knot_cnt > NK) ? NK : int'(knot_cnt));
    have_lo = 0;
    have_hi = 0;
    lo = 0;
    hi = 0;
    if (t < knot_tm[0]) begin
      r.status = hse_pkg::ST_LOW;
    end else if (t > knot_tm[n-1]) begin
      r.status = hse_pkg::ST_HIGH;
    end else begin
      for (int i = n - 1; i >= 0; i--)
        if (!have_lo && t >= knot_tm[i] && !knot_emp[sel][i]) begin
          lo = i;
          have_lo = 1;
        end
      for (int i = 0; i < n; i++)
        if (!have_hi && t < knot_tm[i] && !knot_emp[sel][i]) begin
          hi = i;
          have_hi = 1;
        end
      // at the final time the last knot closes the span, empty or not
      if (!have_hi && t == knot_tm[n-1]) begin
        hi = n - 1;
        have_hi = 1;
      end
      if (!have_lo || !have_hi) begin
        r.status = hse_pkg::ST_NO_KNOT;
      end else if (lo == hi) begin
        r.spline_value = knot_val[sel][lo];
      end else begin
        s  = 64'(t - knot_tm[lo]);
        dt = 64'(32'(knot_tm[hi] - knot_tm[lo]));
        x0 = longint'(knot_val[sel][lo]);
        x1 = longint'(knot_val[sel][hi]);
        m0 = longint'(knot_slp[sel][lo]);
        m1 = longint'(knot_slp[sel][hi]);
        u  = (dt != 0) ? longint'((s << hse_pkg::U_BITS) / dt) : 0;
        u2 = (u * u) >>> hse_pkg::U_BITS;
        u3 = (u2 * u) >>> hse_pkg::U_BITS;
        h01 = 3 * u2 - 2 * u3;
        h10 = u - 2 * u2 + u3;
        h11 = u3 - u2;
        w10 = (longint'(dt) * h10) >>> hse_pkg::U_BITS;
        w11 = (longint'(dt) * h11) >>> hse_pkg::U_BITS;
        acc = x0 + (((x1 - x0) * h01) >>> hse_pkg::U_BITS)
              + ((w10 * m0) >>> hse_pkg::FRAC_BITS_DEF)
              + ((w11 * m1) >>> hse_pkg::FRAC_BITS_DEF);
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        r.spline_value = acc[31:0];
      end
    end
    return r;
  endfunction

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("hermite_spline_evaluator_unit_tb NOT OK");
      $finish;
    end
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (in_valid && !in_stall) begin
      if (in_data.req_type == hse_pkg::REQ_WRITE) begin
        knot_tm[in_data.knot_index] = in_data.knot_time;
        knot_val[in_data.spline_sel][in_data.knot_index] = in_data.knot_value;
        knot_slp[in_data.spline_sel][in_data.knot_index] = in_data.knot_slope;
        knot_emp[in_data.spline_sel][in_data.knot_index] = in_data.knot_empty;
        writes_done++;
      end else begin
        value_q = {value_q, eval_spline(in_data.spline_sel, in_data.query_time)};
      end
      in_valid <= 1'b0;
      send_gap <= draw_gap();
    end else if (!in_valid) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (req_q.size() > 0) begin
        in_data  <= req_q.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // result monitor: after each result, out_stall holds off the next one for a randomly drawn gap
  always @(posedge clk) begin
    hse_pkg::out_res_t exp_res;
    int                gap;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap  <= 0;
    end else if (out_valid && !out_stall) begin
      if (value_q.size() == 0) begin
        $error("unexpected result value=%0d status=%0d", out_data.spline_value,
               out_data.status);
        errors++;
      end else begin
        exp_res = value_q.pop_front();
        if (out_data.spline_value !== exp_res.spline_value) begin
          $error("spline_value expected %0d got %0d", exp_res.spline_value,
                 out_data.spline_value);
          errors++;
        end
        if (out_data.status !== exp_res.status) begin
          $error("status expected %0d got %0d", exp_res.status, out_data.status);
          errors++;
        end
      end
      queries_done++;
      gap = draw_gap();
      recv_gap  <= gap;
      out_stall <= (gap != 0);
    end else if (out_valid && recv_gap > 0) begin
      recv_gap  <= recv_gap - 1;
      out_stall <= (recv_gap > 1);
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (req_q.size() != 0 || in_valid || value_q.size() != 0 || send_gap != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_count(logic [6:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    knot_cnt = v;
    phases++;
  endtask

  task automatic put_write(logic sel, int idx, logic [31:0] t, logic [31:0] v,
                           logic [31:0] m, logic e);
    hse_pkg::in_req_t r;
    r = '0;
    r.req_type   = hse_pkg::REQ_WRITE;
    r.spline_sel = sel;
    r.knot_index = idx[5:0];
    r.knot_time  = t;
    r.knot_value = v;
    r.knot_slope = m;
    r.knot_empty = e;
    r.query_time = $urandom();
    plan_tm[idx] = t;
    req_q = {req_q, r};
    items_sent++;
  endtask

  task automatic put_query(logic sel, logic [31:0] t);
    hse_pkg::in_req_t r;
    r = '0;
    r.req_type   = hse_pkg::REQ_QUERY;
    r.spline_sel = sel;
    r.knot_index = 6'($urandom());
    r.knot_time  = $urandom();
    r.knot_value = $urandom();
    r.knot_slope = $urandom();
    r.knot_empty = 1'($urandom());
    r.query_time = t;
    req_q = {req_q, r};
    items_sent++;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom();
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  // fresh non-decreasing time table; both splines get every knot
  task automatic build_table(logic [31:0] start, int max_step);
    logic [31:0] t;
    t = start;
    for (int i = 0; i < NK; i++) begin
      if (i > 0 && $urandom_range(0, 7) != 0) t = t + $urandom_range(1, max_step);
      put_write(1'b0, i, t, rand_word(), rand_word(), $urandom_range(0, 5) == 0);
      put_write(1'b1, i, t, rand_word(), rand_word(), $urandom_range(0, 5) == 0);
    end
  endtask

  task automatic random_query(int n);
    int i;
    logic [31:0] span;
    i = $urandom_range(0, n - 1);
    case ($urandom_range(0, 9))
      0: put_query(1'($urandom()),
                   (plan_tm[0] > 0) ? $urandom_range(0, plan_tm[0] - 1) : 0);
      1: put_query(1'($urandom()), (plan_tm[n-1] != '1) ?
                   $urandom_range(plan_tm[n-1] + 1, 32'hFFFF_FFFF) : '1);
      2, 3: put_query(1'($urandom()), plan_tm[i]);
      4: put_query(1'($urandom()), $urandom());
      default: begin
        if (i == n - 1) i = (n > 1) ? n - 2 : 0;
        span = plan_tm[(n > 1) ? i + 1 : i] - plan_tm[i];
        put_query(1'($urandom()), plan_tm[i] + $urandom_range(0, span));
      end
    endcase
  endtask

  initial begin
    int n;
    logic [31:0] lo_t, hi_t;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // count still at its reset value of one
    build_table(32'h0001_0000, 32'h0080_0000);
    put_query(1'b0, 32'h0000_0000);
    put_query(1'b1, 32'h0001_0000);
    put_query(1'b0, 32'hFFFF_FFFF);

    set_count(7'd64);
    // first knot empty: nothing at or below a time just past it
    put_write(1'b0, 0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    put_write(1'b0, 1, 32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    put_query(1'b0, 32'h0001_8000);
    put_query(1'b0, 32'h0001_0000);
    put_write(1'b0, 0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    put_query(1'b0, 32'h0000_0000);
    put_query(1'b0, 32'h0001_8000);
    // last two knots share the top time, last one empty: zero span
    put_write(1'b1, 62, 32'hFFFF_FFFF, 32'h1234_5678, 32'h7FFF_FFFF, 1'b0);
    put_write(1'b1, 63, 32'hFFFF_FFFF, 32'hFEDC_BA98, 32'h8000_0000, 1'b1);
    put_query(1'b1, 32'hFFFF_FFFF);
    put_write(1'b1, 63, 32'hFFFF_FFFF, 32'hFEDC_BA98, 32'h8000_0000, 1'b0);
    put_query(1'b1, 32'hFFFF_FFFF);
    put_query(1'b0, 32'hFFFF_FFFF);
    put_query(1'b1, plan_tm[61] + 1);

    set_count(7'd0);
    put_query(1'b0, plan_tm[0]);
    put_query(1'b1, plan_tm[0] + 1);
    set_count(7'd127);
    put_query(1'b0, plan_tm[63]);
    put_query(1'b1, plan_tm[30]);

    // hold the sender until the pipe drains, then restart randomly
    wait_idle();
    build_table($urandom_range(0, 32'h4000_0000), 32'h0100_0000);

    while (items_sent < ITEM_GOAL) begin
      case ($urandom_range(0, 7))
        0: n = 1;
        1: n = 2;
        2: n = 64;
        3: n = $urandom_range(65, 127);
        4: n = $urandom_range(2, 8);
        default: n = $urandom_range(2, 64);
      endcase
      set_count(n[6:0]);
      quiet = ($urandom_range(0, 3) == 0);
      if (n > NK) n = NK;
      if ($urandom_range(0, 9) == 0)
        build_table($urandom_range(0, 32'h1000_0000), $urandom_range(1, 32'h0200_0000));
      // reload a few knots; a moved time stays between its neighbors
      repeat ($urandom_range(2, 10)) begin
        int i;
        i = $urandom_range(0, NK - 1);
        lo_t = (i > 0) ? plan_tm[i-1] : 32'h0;
        hi_t = (i < NK - 1) ? plan_tm[i+1] : 32'hFFFF_FFFF;
        put_write(1'($urandom()), i, ($urandom_range(0, 1) != 0) ? plan_tm[i] :
                  $urandom_range(lo_t, hi_t), rand_word(), rand_word(),
                  $urandom_range(0, 4) == 0);
      end
      repeat ($urandom_range(8, 24)) random_query(n);
    end

    wait_idle();
    repeat (400) @(posedge clk);
    $display("Checked %0d query results and %0d knot writes over %0d count settings.",
             queries_done, writes_done, phases);
    $display("Queries covered in-range, below, above, exact-knot and empty-knot cases.");
    if (errors == 0) begin
      $display("hermite_spline_evaluator_unit_tb OK");
    end else begin
      $display("hermite_spline_evaluator_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
design/hse_pkg.sv
design/hermite_spline_evaluator_unit.sv
test/hermite_spline_evaluator_unit_tb.sv
